[rtl/frame_ring_receive_buffer_macros.svh]
// assertion helpers shared by the receive buffer rtl
`ifndef FRAME_RING_RECEIVE_BUFFER_MACROS_SVH
`define FRAME_RING_RECEIVE_BUFFER_MACROS_SVH

// condition in this cycle implies consequence in the same cycle
`define FRB_ASSERT_SAME(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("frb assertion failed");

// condition in this cycle implies consequence in the next cycle
`define FRB_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("frb assertion failed");

`endif

[rtl/frb_pkg.sv]
package frb_pkg;

  localparam int FRAME_SLOTS = 8;
  localparam int FRAME_BYTES = 32;

  localparam int SLOT_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int POS_W  = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int ADDR_W = $clog2(FRAME_SLOTS * FRAME_BYTES);

  localparam int DATA_W   = 8;
  localparam int OFFSET_W = 5;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_RELEASE = 2'd2
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [DATA_W-1:0]   data;
    logic [OFFSET_W-1:0] offset;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              read_valid;
    logic              frame_available;
  } result_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } store_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } store_rd_t;

endpackage

[rtl/frb_store.sv]
module frb_store (
  input  logic              clk,
  input  frb_pkg::store_wr_t wr,
  input  frb_pkg::store_rd_t rd,
  output logic [frb_pkg::DATA_W-1:0] rdata
);
  import frb_pkg::*;

  logic [DATA_W-1:0] mem [FRAME_SLOTS*FRAME_BYTES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule

[rtl/frame_ring_receive_buffer.sv]
// channel   | ports                 | transfer
// ----------+-----------------------+---------------------------------------
// command   | start, busy, cmd      | start high and busy low at a clock edge
// result    | done, result          | done high for one cycle, no back-pressure
//
// one command is taken every cycle while busy is low; busy is only raised while rst is high
// the result of a command shows in the cycle after its transfer, set by the
// registered read port of the frame store
// synchronous reset clears slots, write position and complete flags; the
// frame store itself is not cleared
// the receiver cannot stall, so results never queue up
module frame_ring_receive_buffer (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  frb_pkg::cmd_t    cmd,
  output logic             done,
  output frb_pkg::result_t result
);
  import frb_pkg::*;

  `include "frame_ring_receive_buffer_macros.svh"

  localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(FRAME_BYTES - 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(FRAME_SLOTS - 1);

  logic [SLOT_W-1:0] write_slot, write_slot_next;
  logic [POS_W-1:0]  write_position, write_position_next;
  logic [SLOT_W-1:0] read_slot, read_slot_next;
  logic              complete_flags [FRAME_SLOTS];
  logic              complete_flags_next [FRAME_SLOTS];

  logic accept;
  logic ready_now;
  logic rd_valid_next;
  logic rd_keep_next;
  logic avail_next;
  logic rd_valid;
  logic rd_keep;
  logic avail;
  logic frame_closing;
  logic releasing;

  store_wr_t         st_wr;
  store_rd_t         st_rd;
  logic [DATA_W-1:0] st_rdata;

  assign busy   = rst;
  assign accept = start && !busy;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_LAST) ? '0 : s + 1'b1;
  endfunction

  assign ready_now = (read_slot != write_slot) && complete_flags[read_slot];

  always_comb begin
    write_slot_next     = write_slot;
    write_position_next = write_position;
    read_slot_next      = read_slot;
    complete_flags_next = complete_flags;
    rd_valid_next       = 1'b0;
    rd_keep_next        = 1'b0;

    st_wr.en   = 1'b0;
    st_wr.addr = ADDR_W'(write_slot) * ADDR_W'(FRAME_BYTES) + ADDR_W'(write_position);
    st_wr.data = cmd.data;
    st_rd.en   = 1'b0;
    st_rd.addr = ADDR_W'(read_slot) * ADDR_W'(FRAME_BYTES) + ADDR_W'(cmd.offset);

    if (accept) begin
      unique case (cmd.op)
        OP_WRITE: begin
          st_wr.en = 1'b1;
          if (write_position == POS_LAST) begin
            complete_flags_next[write_slot] = 1'b1;
            write_slot_next                 = slot_inc(write_slot);
            write_position_next             = '0;
          end else begin
            write_position_next = write_position + 1'b1;
          end
        end
        OP_READ: begin
          rd_valid_next = ready_now;
          // offsets past the frame end report availability but no byte
          rd_keep_next  = ready_now && (32'(cmd.offset) < 32'(FRAME_BYTES));
          st_rd.en      = ready_now;
        end
        OP_RELEASE: begin
          complete_flags_next[read_slot] = 1'b0;
          read_slot_next                 = slot_inc(read_slot);
        end
        default: begin
        end
      endcase
    end

    // availability is reported on the state left after this command
    avail_next = complete_flags_next[read_slot_next] && (read_slot_next != write_slot_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot     <= '0;
      write_position <= '0;
      read_slot      <= '0;
      for (int i = 0; i < FRAME_SLOTS; i++) begin
        complete_flags[i] <= 1'b0;
      end
      done     <= 1'b0;
      rd_valid <= 1'b0;
      rd_keep  <= 1'b0;
      avail    <= 1'b0;
    end else begin
      write_slot     <= write_slot_next;
      write_position <= write_position_next;
      read_slot      <= read_slot_next;
      complete_flags <= complete_flags_next;
      done           <= accept;
      rd_valid       <= rd_valid_next;
      rd_keep        <= rd_keep_next;
      avail          <= avail_next;
    end
  end

  frb_store u_store (
    .clk   (clk),
    .wr    (st_wr),
    .rd    (st_rd),
    .rdata (st_rdata)
  );

  assign result.read_data       = rd_keep ? st_rdata : '0;
  assign result.read_valid      = rd_valid;
  assign result.frame_available = avail;

  assign frame_closing = accept && cmd.op == OP_WRITE && write_position == POS_LAST;
  assign releasing     = accept && cmd.op == OP_RELEASE;

  `FRB_ASSERT_NEXT(a_done_follows_accept, accept, done)
  `FRB_ASSERT_SAME(a_data_needs_valid, done && !result.read_valid, result.read_data == '0)
  `FRB_ASSERT_NEXT(a_frame_close_pos, frame_closing, write_position == '0)
  `FRB_ASSERT_NEXT(a_frame_close_slot, frame_closing, write_slot != $past(write_slot))
  `FRB_ASSERT_NEXT(a_release_clears, releasing, !complete_flags[$past(read_slot)])

endmodule

[tb/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import frb_pkg::*;

  // op field value that the package enum leaves unnamed
  localparam logic [1:0] OP_CODE_UNUSED = 2'd3;
  localparam int STORE_BYTES = FRAME_SLOTS * FRAME_BYTES;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  cmd_t    cmd = '0;
  logic    done;
  result_t result;

  frame_ring_receive_buffer u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  always #2 clk = ~clk;

  // local copy of the ring
  logic [DATA_W-1:0] frame_copy [STORE_BYTES];
  bit                byte_written [STORE_BYTES];
  bit                slot_complete [FRAME_SLOTS];
  int unsigned       wr_slot;
  int unsigned       wr_pos;
  int unsigned       rd_slot;

  result_t expected_results [$];
  int      fail_count;
  int      items_sent;
  bit      burst_mode;

  function automatic int unsigned next_slot(int unsigned s);
    return (s + 1 >= FRAME_SLOTS) ? 0 : s + 1;
  endfunction

  function automatic bit oldest_frame_ready();
    return rd_slot != wr_slot && slot_complete[rd_slot];
  endfunction

  function automatic result_t apply_command(cmd_t c);
    result_t r;
    int      idx;
    r = '0;
    case (c.op)
      OP_WRITE: begin
        idx = wr_slot * FRAME_BYTES + wr_pos;
        frame_copy[idx] = c.data;
        byte_written[idx] = 1'b1;
        if (wr_pos + 1 >= FRAME_BYTES) begin
          slot_complete[wr_slot] = 1'b1;
          wr_slot = next_slot(wr_slot);
          wr_pos = 0;
        end else begin
          wr_pos++;
        end
      end
      OP_READ: begin
        if (oldest_frame_ready()) begin
          r.read_valid = 1'b1;
          if (c.offset < FRAME_BYTES)
            r.read_data = frame_copy[rd_slot * FRAME_BYTES + c.offset];
        end
      end
      OP_RELEASE: begin
        slot_complete[rd_slot] = 1'b0;
        rd_slot = next_slot(rd_slot);
      end
      default: ;
    endcase
    r.frame_available = oldest_frame_ready();
    return r;
  endfunction

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // compare each result with the oldest expectation, then log any transfer
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (done === 1'b1) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, result);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("read_data", want.read_data, result.read_data);
          check_field("read_valid", DATA_W'(want.read_valid),
                      DATA_W'(result.read_valid));
          check_field("frame_available", DATA_W'(want.frame_available),
                      DATA_W'(result.frame_available));
        end
      end
      if (start && busy === 1'b0)
        expected_results.push_back(apply_command(cmd));
    end
  end

  function automatic cmd_t make_cmd(logic [1:0] code, logic [DATA_W-1:0] d,
                                    logic [OFFSET_W-1:0] off);
    cmd_t c;
    c.op = op_t'(code);
    c.data = d;
    c.offset = off;
    return c;
  endfunction

  function automatic cmd_t random_cmd(logic [1:0] code);
    return make_cmd(code, DATA_W'($urandom), OFFSET_W'($urandom));
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst_mode)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic send_cmd(input cmd_t c);
    int gap;
    int base;
    int k;
    bit found;
    @(negedge clk);
    // never read a store byte that has not been written since reset
    if (c.op == OP_READ && c.offset < FRAME_BYTES &&
        !byte_written[rd_slot * FRAME_BYTES + c.offset]) begin
      found = 1'b0;
      base = $urandom_range(0, FRAME_BYTES - 1);
      for (k = 0; k < FRAME_BYTES && !found; k++) begin
        if (byte_written[rd_slot * FRAME_BYTES + (base + k) % FRAME_BYTES]) begin
          c.offset = OFFSET_W'((base + k) % FRAME_BYTES);
          found = 1'b1;
        end
      end
      if (!found)
        c.op = op_t'(OP_CODE_UNUSED);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy !== 1'b0);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      cmd <= random_cmd(2'($urandom));
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic write_byte(input logic [DATA_W-1:0] d);
    send_cmd(make_cmd(OP_WRITE, d, OFFSET_W'($urandom)));
  endtask

  task automatic read_byte(input logic [OFFSET_W-1:0] off);
    send_cmd(make_cmd(OP_READ, DATA_W'($urandom), off));
  endtask

  task automatic release_frame();
    send_cmd(random_cmd(OP_RELEASE));
  endtask

  // unused code, non-read ops, reads with no frame and releases on an empty ring
  task automatic test_directed();
    int k;
    burst_mode = 1'b0;
    send_cmd(make_cmd(OP_CODE_UNUSED, '1, '1));
    write_byte('1);
    write_byte('0);
    read_byte('0);
    read_byte(OFFSET_W'(1));
    send_cmd(make_cmd(OP_WRITE, 8'h5a, '1));
    read_byte('1);
    // release with nothing complete, then walk the read slot once round the ring
    for (k = 0; k < FRAME_SLOTS; k++)
      release_frame();
    send_cmd(make_cmd(OP_CODE_UNUSED, '0, '0));
    send_cmd(make_cmd(OP_RELEASE, '1, '1));
  endtask

  // full frames with random content, reads of the oldest frame and releases
  task automatic test_frame_flow(input int n_items);
    int k;
    int n;
    while (items_sent < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        burst_mode = ($urandom_range(0, 3) == 0);
        for (k = 0; k < FRAME_BYTES; k++) begin
          write_byte(DATA_W'($urandom));
          if ($urandom_range(0, 9) == 0)
            read_byte(OFFSET_W'($urandom));
        end
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++)
          read_byte(OFFSET_W'($urandom));
        if ($urandom_range(0, 99) < 85)
          release_frame();
      end else begin
        burst_mode = 1'b0;
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++)
          send_cmd(random_cmd(2'($urandom)));
      end
    end
  endtask

  // fill past the whole ring without releasing, then drain past the write slot
  task automatic test_overrun();
    int k;
    burst_mode = 1'b0;
    for (k = 0; k < (FRAME_SLOTS + 1) * FRAME_BYTES + 5; k++) begin
      write_byte(DATA_W'($urandom));
      if ($urandom_range(0, 7) == 0)
        read_byte(OFFSET_W'($urandom));
    end
    for (k = 0; k < FRAME_SLOTS + 2; k++) begin
      read_byte(OFFSET_W'($urandom));
      release_frame();
    end
  endtask

  task automatic test_noise(input int n_items);
    int k;
    for (k = 0; k < n_items; k++) begin
      burst_mode = ($urandom_range(0, 4) == 0);
      send_cmd(random_cmd(2'($urandom)));
    end
  endtask

  initial begin
    int wait_cycles;
    wr_slot = 0;
    wr_pos = 0;
    rd_slot = 0;
    fail_count = 0;
    items_sent = 0;
    burst_mode = 1'b0;
    foreach (slot_complete[i]) slot_complete[i] = 1'b0;
    foreach (byte_written[i]) byte_written[i] = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_frame_flow(1500);
    test_overrun();
    test_noise(200);

    @(negedge clk);
    start <= 1'b0;
    wait_cycles = 0;
    while (expected_results.size() != 0 && wait_cycles < 50) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (3) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d results still pending, expected none", $time,
               expected_results.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
